### sv/rcfs_pkg.sv
// Shared types and constants for the RGB color fade sequencer.
// No dependencies; imported by rcfs_ctrl, rcfs_dp and the top level.
package rcfs_pkg;

    localparam int CH_W       = 8;          // bits per color channel
    localparam int COLOR_W    = 3 * CH_W;   // red | green | blue
    localparam int PAL_REGS   = 4;          // palette registers that exist
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 3;
    localparam int PERIOD_W   = 16;
    localparam int WAIT_W     = 20;         // holds 10 * 65535 - 1
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;

    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 3'd1;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;

    localparam logic [MODE_W-1:0] MODE_STATIC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FADE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_JUMP   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAL0   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAL1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAL2   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PAL3   = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SEARCH,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_REWIND,
        CMD_HOLD,
        CMD_STATIC,
        CMD_JUMP,
        CMD_SEARCH_INIT,
        CMD_SEARCH_STEP
    } t_dp_cmd;

    typedef struct packed {
        logic              run;
        logic [MODE_W-1:0] mode;
        logic              hold;         // started and wait count nonzero
        logic              search_hit;   // current pair differs
        logic              search_last;  // last allowed try
    } t_dp_stat;

endpackage

### sv/rcfs_ctrl.sv
// Controller state machine for the RGB color fade sequencer.
// Depends on rcfs_pkg; drives rcfs_dp through t_dp_cmd, reads t_dp_stat.
module rcfs_ctrl
    import rcfs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_free,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_emit,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = CMD_NONE;
        o_in_ready = 1'b0;
        o_emit     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_EMIT;
                if (!i_stat.run) begin
                    o_cmd = CMD_REWIND;
                end else begin
                    unique case (i_stat.mode)
                        MODE_FADE: begin
                            if (i_stat.hold) begin
                                o_cmd = CMD_HOLD;
                            end else begin
                                o_cmd   = CMD_SEARCH_INIT;
                                n_state = ST_SEARCH;
                            end
                        end
                        MODE_JUMP: begin
                            o_cmd = i_stat.hold ? CMD_HOLD : CMD_JUMP;
                        end
                        default: begin
                            o_cmd = CMD_STATIC;   // unused code runs as static
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                o_cmd = CMD_SEARCH_STEP;
                if (i_stat.search_hit || i_stat.search_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_emit = i_out_free;
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/rcfs_dp.sv
// Datapath for the RGB color fade sequencer: config registers, sequence
// state and the one-try-per-cycle pair search. Depends on rcfs_pkg.
module rcfs_dp
    import rcfs_pkg::*;
#(
    parameter int PALETTE_SIZE = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_run,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic [COLOR_W-1:0]    o_color,
    output logic                  o_changed
);

    localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
    // wide enough to hold PAL_REGS for the range compare
    localparam int PIW   = (IDX_W > 3) ? IDX_W : 3;

    // config
    logic [MODE_W-1:0]   r_mode;
    logic [COUNT_W-1:0]  r_count;
    logic [PERIOD_W-1:0] r_period;
    logic [COLOR_W-1:0]  r_pal [PAL_REGS];

    // sequence state
    logic [COLOR_W-1:0] r_shown;
    logic [IDX_W-1:0]   r_pair;
    logic [WAIT_W-1:0]  r_wait;
    logic               r_started;
    logic               r_run;
    logic               r_changed;

    // search state
    logic [COLOR_W-1:0] r_cur;
    logic [IDX_W-1:0]   r_sidx;
    logic [CNT_W-1:0]   r_tries;

    logic [COUNT_W-1:0]  n3;
    logic [CNT_W-1:0]    n_used;
    logic [IDX_W-1:0]    pair_clamped;
    logic [IDX_W-1:0]    sidx_next;
    logic [CNT_W-1:0]    sidx_p1;
    logic [IDX_W-1:0]    jump_next;
    logic [CNT_W-1:0]    jump_p1;
    logic [COLOR_W-1:0]  tgt;
    logic [COLOR_W-1:0]  pal0;
    logic [COLOR_W-1:0]  jump_color;
    logic [PERIOD_W-1:0] period_eff;
    logic [WAIT_W-1:0]   pe_w;
    logic [WAIT_W-1:0]   fade_wait;
    logic [WAIT_W-1:0]   jump_wait;
    logic [IDX_W-1:0]    jump_idx;

    function automatic logic [COLOR_W-1:0] pal_at(input logic [IDX_W-1:0] idx);
        logic [PIW-1:0]     ext;
        logic [COLOR_W-1:0] v;
        ext = PIW'(idx);
        v   = '0;
        if (ext < PIW'(PAL_REGS)) begin
            v = r_pal[ext[1:0]];
        end
        return v;
    endfunction

    function automatic logic [COLOR_W-1:0] step_toward(
        input logic [COLOR_W-1:0] cur,
        input logic [COLOR_W-1:0] dst
    );
        logic [COLOR_W-1:0] res;
        logic [CH_W-1:0]    a;
        logic [CH_W-1:0]    b;
        res = '0;
        for (int k = 0; k < 3; k++) begin
            a = cur[k*CH_W +: CH_W];
            b = dst[k*CH_W +: CH_W];
            if (a > b) begin
                a = a - CH_W'(1);
            end else if (a < b) begin
                a = a + CH_W'(1);
            end
            res[k*CH_W +: CH_W] = a;
        end
        return res;
    endfunction

    always_comb begin
        // effective color count: zero means one, clamp to palette size
        if (r_count == '0) begin
            n3 = COUNT_W'(1);
        end else if (r_count > COUNT_W'(PALETTE_SIZE)) begin
            n3 = COUNT_W'(PALETTE_SIZE);
        end else begin
            n3 = r_count;
        end
        n_used = CNT_W'(n3);

        pair_clamped = (CNT_W'(r_pair) >= n_used) ? '0 : r_pair;

        sidx_p1   = CNT_W'(r_sidx) + CNT_W'(1);
        sidx_next = (sidx_p1 >= n_used) ? '0 : IDX_W'(sidx_p1);
        tgt       = pal_at(sidx_next);

        jump_idx   = r_started ? pair_clamped : '0;
        jump_p1    = CNT_W'(jump_idx) + CNT_W'(1);
        jump_next  = (jump_p1 >= n_used) ? '0 : IDX_W'(jump_p1);
        jump_color = pal_at(jump_idx);
        pal0       = pal_at('0);

        period_eff = (r_period == '0) ? PERIOD_W'(1) : r_period;
        pe_w       = WAIT_W'(period_eff);
        fade_wait  = pe_w - WAIT_W'(1);
        jump_wait  = (pe_w << 3) + (pe_w << 1) - WAIT_W'(1);   // 10x period
    end

    assign o_stat.run         = r_run;
    assign o_stat.mode        = r_mode;
    assign o_stat.hold        = r_started && (r_wait != '0);
    assign o_stat.search_hit  = (r_cur != tgt);
    assign o_stat.search_last = ((r_tries + CNT_W'(1)) == n_used);

    assign o_color   = r_shown;
    assign o_changed = r_changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_STATIC;
            r_count   <= COUNT_RESET;
            r_period  <= PERIOD_RESET;
            for (int i = 0; i < PAL_REGS; i++) begin
                r_pal[i] <= '0;
            end
            r_shown   <= '0;
            r_pair    <= '0;
            r_wait    <= '0;
            r_started <= 1'b0;
            r_run     <= 1'b0;
            r_changed <= 1'b0;
        end else begin
            case (i_cmd)
                CMD_LOAD: begin
                    r_run <= i_run;
                end
                CMD_REWIND: begin
                    r_pair    <= '0;
                    r_wait    <= '0;
                    r_started <= 1'b0;
                    r_changed <= 1'b0;
                end
                CMD_HOLD: begin
                    r_wait    <= r_wait - WAIT_W'(1);
                    r_pair    <= pair_clamped;
                    r_changed <= 1'b0;
                end
                CMD_STATIC: begin
                    r_changed <= !r_started || (r_shown != pal0);
                    r_shown   <= pal0;
                    r_started <= 1'b1;
                    r_pair    <= '0;
                    r_wait    <= '0;
                end
                CMD_JUMP: begin
                    r_shown   <= jump_color;
                    r_pair    <= jump_next;
                    r_wait    <= jump_wait;
                    r_started <= 1'b1;
                    r_changed <= 1'b1;
                end
                CMD_SEARCH_INIT: begin
                    r_pair <= pair_clamped;
                end
                CMD_SEARCH_STEP: begin
                    if (o_stat.search_hit) begin
                        r_shown   <= step_toward(r_cur, tgt);
                        r_pair    <= r_sidx;
                        r_started <= 1'b1;
                        r_wait    <= fade_wait;
                        r_changed <= 1'b1;
                    end else if (o_stat.search_last) begin
                        // every pair equal: nothing shown, stay unstarted
                        r_pair    <= '0;
                        r_wait    <= '0;
                        r_started <= 1'b0;
                        r_changed <= 1'b0;
                    end
                end
                default: begin
                end
            endcase

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_MODE: begin
                        r_mode    <= i_cfg_wdata[MODE_W-1:0];
                        r_pair    <= '0;
                        r_wait    <= '0;
                        r_started <= 1'b0;
                    end
                    CFG_COUNT:  r_count  <= i_cfg_wdata[COUNT_W-1:0];
                    CFG_PERIOD: r_period <= i_cfg_wdata[PERIOD_W-1:0];
                    CFG_PAL0:   r_pal[0] <= i_cfg_wdata[COLOR_W-1:0];
                    CFG_PAL1:   r_pal[1] <= i_cfg_wdata[COLOR_W-1:0];
                    CFG_PAL2:   r_pal[2] <= i_cfg_wdata[COLOR_W-1:0];
                    CFG_PAL3:   r_pal[3] <= i_cfg_wdata[COLOR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // search registers carry no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_SEARCH_INIT) begin
            r_cur   <= r_started ? r_shown : pal0;
            r_sidx  <= r_started ? pair_clamped : '0;
            r_tries <= '0;
        end else if (i_cmd == CMD_SEARCH_STEP && !o_stat.search_hit) begin
            r_cur   <= tgt;
            r_sidx  <= sidx_next;
            r_tries <= r_tries + CNT_W'(1);
        end
    end

endmodule

### sv/rgb_color_fade_sequencer_core.sv
// Top level of the RGB color fade sequencer: controller, datapath and
// the output register stage. Depends on rcfs_pkg, rcfs_ctrl, rcfs_dp.
//
//  channel   | direction | transaction carries
//  ----------+-----------+---------------------------------------------
//  s_axis_*  | in        | one tick: run_enable
//  m_axis_*  | out       | one result per tick: duty values, changed
//  i_cfg_*   | in        | register write, no wait, no read-back
//
// A tick passes through accept, evaluate and emit steps plus, in fade mode when a new step
// is due, one search step per palette pair tried (one pair a cycle), up to PALETTE_SIZE pairs.
// Reset is synchronous, active low; all config registers return to their reset
// values and the sequence rewinds.
// The output register lets the next tick be taken while a result waits; a stalled
// result holds the core in its emit step.
module rgb_color_fade_sequencer_core
    import rcfs_pkg::*;
#(
    parameter int PALETTE_SIZE = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // tick input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] run_enable, [7:1] zero
    // duty output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [7:0] duty_red,
                                                  // [15:8] duty_green,
                                                  // [23:16] duty_blue,
                                                  // [24] duty_changed,
                                                  // [31:25] zero
);

    t_dp_stat           stat;
    t_dp_cmd            cmd;
    logic               emit;
    logic               out_free;
    logic [COLOR_W-1:0] color;
    logic               changed;

    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    // output slot is free when empty or being drained this cycle
    assign out_free = !r_m_valid || m_axis_tready;

    rcfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_emit     (emit),
        .o_cmd      (cmd)
    );

    rcfs_dp #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_run       (s_axis_tdata[0]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_color     (color),
        .o_changed   (changed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // red is the top channel of the color word, sent first
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_m_data <= OUT_DATA_W'({changed,
                                     color[CH_W-1:0],
                                     color[2*CH_W-1:CH_W],
                                     color[3*CH_W-1:2*CH_W]});
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

### test/testbench.sv
// Self-checking testbench for rgb_color_fade_sequencer_core: static, fade and jump sequences
// are predicted tick by tick and compared with every duty transaction.
// Depends on rcfs_pkg and the core RTL only.
module testbench;
    import rcfs_pkg::*;

    localparam int RANDOM_TICKS = 450;
    localparam int SETTLE_CYCLES = 16;       // longer than a tick with a full pair search
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;   // unused code, runs as static

    // one expected duty transaction
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            changed;
    } t_duty;

    // Shadow of the sequencer: config, sequence state and expected duties.
    class t_duty_tracker;
        logic [MODE_W-1:0]   mode;
        logic [COUNT_W-1:0]  count;
        logic [PERIOD_W-1:0] period;
        logic [COLOR_W-1:0]  palette [PAL_REGS];
        logic [COLOR_W-1:0]  shown;
        int unsigned         pair;
        logic [WAIT_W-1:0]   wait_left;
        bit                  started;
        t_duty               pending_duty [$];
        int                  errors;

        function new();
            mode = MODE_STATIC;
            count = COUNT_RESET;
            period = PERIOD_RESET;
            foreach (palette[i]) palette[i] = '0;
            shown = '0;
            errors = 0;
            rewind();
        endfunction

        function void rewind();
            pair = 0;
            wait_left = '0;
            started = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_MODE: begin
                    mode = val[MODE_W-1:0];
                    rewind();               // mode write restarts the sequence
                end
                CFG_COUNT:  count = val[COUNT_W-1:0];
                CFG_PERIOD: period = val[PERIOD_W-1:0];
                CFG_PAL0:   palette[0] = val[COLOR_W-1:0];
                CFG_PAL1:   palette[1] = val[COLOR_W-1:0];
                CFG_PAL2:   palette[2] = val[COLOR_W-1:0];
                CFG_PAL3:   palette[3] = val[COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        // every channel that differs moves one count toward the target
        function logic [COLOR_W-1:0] fade_one(logic [COLOR_W-1:0] cur, logic [COLOR_W-1:0] tgt);
            logic [COLOR_W-1:0] res;
            logic [CH_W-1:0]    a;
            logic [CH_W-1:0]    b;
            for (int k = 0; k < 3; k++) begin
                a = cur[k*CH_W +: CH_W];
                b = tgt[k*CH_W +: CH_W];
                if (a > b)
                    a = a - 1'b1;
                else if (a < b)
                    a = a + 1'b1;
                res[k*CH_W +: CH_W] = a;
            end
            return res;
        endfunction

        // note an accepted tick and queue the duty it must produce
        function void advance_tick(bit run);
            int unsigned        n;
            int unsigned        per;
            int unsigned        idx;
            int unsigned        nx;
            logic [COLOR_W-1:0] cur;
            bit                 hit;
            bit                 changed;
            t_duty              d;

            changed = 1'b0;
            n = (count == 0) ? 1 : ((count > PAL_REGS) ? PAL_REGS : count);
            per = (period == 0) ? 1 : period;
            if (pair >= n) pair = 0;

            if (!run) begin
                rewind();
            end else if (mode == MODE_FADE) begin
                if (started && wait_left != 0) begin
                    wait_left = wait_left - 1'b1;
                end else begin
                    // first step starts from color 0, later ones from what is shown
                    cur = started ? shown : palette[0];
                    idx = started ? pair : 0;
                    hit = 1'b0;
                    for (int t = 0; t < n; t++) begin
                        nx = (idx + 1 >= n) ? 0 : idx + 1;
                        if (cur != palette[nx]) begin
                            shown = fade_one(cur, palette[nx]);
                            hit = 1'b1;
                            break;
                        end
                        idx = nx;               // equal pair: skip within this tick
                        cur = palette[nx];
                    end
                    if (hit) begin
                        pair = idx;
                        started = 1'b1;
                        wait_left = WAIT_W'(per - 1);
                        changed = 1'b1;
                    end else begin
                        rewind();
                    end
                end
            end else if (mode == MODE_JUMP) begin
                if (started && wait_left != 0) begin
                    wait_left = wait_left - 1'b1;
                end else begin
                    idx = started ? pair : 0;
                    shown = palette[idx];
                    pair = (idx + 1 >= n) ? 0 : idx + 1;
                    wait_left = WAIT_W'(per * 10 - 1);
                    started = 1'b1;
                    changed = 1'b1;
                end
            end else begin
                // static, and the unused mode code
                if (!started || shown != palette[0]) begin
                    shown = palette[0];
                    changed = 1'b1;
                end
                started = 1'b1;
                pair = 0;
                wait_left = '0;
            end

            d.red = shown[23:16];
            d.green = shown[15:8];
            d.blue = shown[7:0];
            d.changed = changed;
            pending_duty.push_back(d);
        endfunction

        function void check_duty(logic [OUT_DATA_W-1:0] data);
            t_duty exp_d;
            if (pending_duty.size() == 0) begin
                $error("duty transaction with no tick pending: %h", data);
                errors++;
                return;
            end
            exp_d = pending_duty.pop_front();
            if (data[7:0] !== exp_d.red) begin
                $error("duty_red expected %0d got %0d", exp_d.red, data[7:0]);
                errors++;
            end
            if (data[15:8] !== exp_d.green) begin
                $error("duty_green expected %0d got %0d", exp_d.green, data[15:8]);
                errors++;
            end
            if (data[23:16] !== exp_d.blue) begin
                $error("duty_blue expected %0d got %0d", exp_d.blue, data[23:16]);
                errors++;
            end
            if (data[24] !== exp_d.changed) begin
                $error("duty_changed expected %0d got %0d", exp_d.changed, data[24]);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;     // [0] run_enable, [7:1] zero
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;          // [7:0] red, [15:8] green,
                                                  // [23:16] blue, [24] changed

    t_duty_tracker tracker;
    int            ticks_sent = 0;
    int            cycles = 0;
    int            rx_stall = 0;
    bit            quiet = 1'b0;       // phase with no idling on either side
    int            drop_pct = 5;       // chance of a low run flag

    rgb_color_fade_sequencer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycles <= cycles + 1;

    initial begin
        while (cycles <= CYCLE_LIMIT) @(posedge i_clk);
        $display("testbench: errors");
        $finish;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result side: check each duty transaction, then choose the next tready.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_duty(m_axis_tdata);
        if (rx_stall > 0) begin
            rx_stall = rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0) rx_stall = pick_gap();
        end
    end

    // One register write; the model follows at the capturing edge.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        tracker.write_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One tick transaction; tvalid stays high across back-to-back ticks.
    task automatic send_tick(bit run);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, run};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.advance_tick(run);
        ticks_sent++;
    endtask

    // Hold the sender until all duties are back, then let the core settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_duty.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [COLOR_W-1:0] near_color(logic [COLOR_W-1:0] base);
        logic [COLOR_W-1:0] c;
        int v;
        for (int k = 0; k < 3; k++) begin
            v = int'(base[k*CH_W +: CH_W]) + $urandom_range(0, 6) - 3;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            c[k*CH_W +: CH_W] = v[CH_W-1:0];
        end
        return c;
    endfunction

    // Palette entry: mostly close to its neighbor so fades finish quickly.
    function automatic logic [COLOR_W-1:0] pick_color(logic [COLOR_W-1:0] prev);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return prev;
            3: return COLOR_W'($urandom_range(0, 24'hFFFFFF));
            default: return near_color(prev);
        endcase
    endfunction

    task automatic pick_setting();
        logic [COLOR_W-1:0] c;
        int r;
        if ($urandom_range(0, 9) < 7) begin
            r = $urandom_range(0, 9);
            cfg_write(CFG_MODE, CFG_DATA_W'((r < 2) ? MODE_STATIC :
                                            (r == 2) ? MODE_SPARE :
                                            (r < 7) ? MODE_FADE : MODE_JUMP));
        end
        if ($urandom_range(0, 9) < 6)
            cfg_write(CFG_COUNT,
                      CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                              : $urandom_range(2, 4)));
        if ($urandom_range(0, 9) < 6) begin
            r = $urandom_range(0, 9);
            cfg_write(CFG_PERIOD,
                      CFG_DATA_W'((r == 0) ? 0 : (r == 1) ? 16'hFFFF : $urandom_range(1, 3)));
        end
        if ($urandom_range(0, 9) < 6) begin
            c = COLOR_W'($urandom_range(0, 24'hFFFFFF));
            c = pick_color(c);
            cfg_write(CFG_PAL0, c);
            c = pick_color(c);
            cfg_write(CFG_PAL1, c);
            c = pick_color(c);
            cfg_write(CFG_PAL2, c);
            c = pick_color(c);
            cfg_write(CFG_PAL3, c);
        end
        quiet = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 9);
        drop_pct = (r < 6) ? 2 : (r < 9) ? 10 : 40;
    endtask

    initial begin
        int n;
        tracker = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: static black, a low run flag in between
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        drain();

        // unused mode code acts static; zero count
        cfg_write(CFG_PAL0, 24'hFFFFFF);
        cfg_write(CFG_PAL1, 24'h000000);
        cfg_write(CFG_PAL2, 24'hFFFFFF);
        cfg_write(CFG_PAL3, 24'h00FF00);
        cfg_write(CFG_COUNT, 24'd0);
        cfg_write(CFG_MODE, CFG_DATA_W'(MODE_SPARE));
        send_tick(1'b1);
        send_tick(1'b1);
        drain();

        // fade from color 0 with zero period, count above palette size,
        // an equal pair skipped at the start, run flag dropped mid-fade
        cfg_write(CFG_MODE, CFG_DATA_W'(MODE_FADE));
        cfg_write(CFG_COUNT, 24'd7);
        cfg_write(CFG_PERIOD, 24'd0);
        cfg_write(CFG_PAL0, 24'h010203);
        cfg_write(CFG_PAL1, 24'h010203);
        cfg_write(CFG_PAL2, 24'h020201);
        cfg_write(CFG_PAL3, 24'h010203);
        for (int i = 0; i < 8; i++) send_tick(i != 6);
        drain();

        // every pair equal: nothing is written
        cfg_write(CFG_PAL2, 24'h010203);
        send_tick(1'b1);
        send_tick(1'b1);
        drain();

        // jump with the longest period
        cfg_write(CFG_MODE, CFG_DATA_W'(MODE_JUMP));
        cfg_write(CFG_PERIOD, 24'h00FFFF);
        cfg_write(CFG_COUNT, 24'd2);
        send_tick(1'b1);
        send_tick(1'b1);
        drain();

        n = ticks_sent + RANDOM_TICKS;
        while (ticks_sent < n) begin
            pick_setting();
            repeat ($urandom_range(10, 60))
                send_tick($urandom_range(0, 99) >= drop_pct);
            drain();
        end

        if (tracker.errors == 0 && tracker.pending_duty.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
